// ===== src/ip_address_text_parser_assert.svh =====
// Assertion macros for the IP address text parser.
`ifndef IP_ADDRESS_TEXT_PARSER_ASSERT_SVH
`define IP_ADDRESS_TEXT_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IPAT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define IPAT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ipat_pkg.sv =====
// Shared types, constants and character helpers for the IP address text parser.
package ipat_pkg;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_V4   = 2'd1;
	localparam logic [1:0] KIND_V6   = 2'd2;

	localparam logic [9:0] V4_MAX_VALUE  = 10'd255;
	localparam logic [2:0] V4_LAST_PART  = 3'd3;
	localparam logic [2:0] V4_PARTS      = 3'd4;
	localparam logic [2:0] V4_MAX_DIGITS = 3'd3;
	localparam logic [3:0] V6_GROUPS     = 4'd8;
	localparam logic [3:0] V6_GAP_GROUPS = 4'd7;
	localparam logic [2:0] V6_MAX_DIGITS = 3'd4;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HI = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;

	typedef struct packed {
		logic [7:0] in_char;
		logic       last;
	} text_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
	} addr_t;

	typedef enum logic [1:0] {
		TRIM_LEAD,
		TRIM_BODY,
		TRIM_TAIL
	} trim_t;

	// per-character control from the trim logic to the form trackers
	typedef struct packed {
		logic step;
		logic feed;
		logic kill;
		logic last;
	} step_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c inside {[CH_0:CH_9], [CH_LA:CH_LF_HI], [CH_UA:CH_UF]});
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		t = '0;
		if (c inside {[CH_0:CH_9]}) begin
			t = c - CH_0;
		end else if (c inside {[CH_LA:CH_LF_HI]}) begin
			t = c - CH_LA + 8'd10;
		end else if (c inside {[CH_UA:CH_UF]}) begin
			t = c - CH_UA + 8'd10;
		end
		return t[3:0];
	endfunction

endpackage

// ===== src/ipat_v4.sv =====
// Dotted-decimal tracker: part counting, value check and address assembly.
module ipat_v4 import ipat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  step_t       ctl,
	input  logic [7:0]  ch,
	output logic        fin_ok,
	output logic [31:0] fin_addr
);

	logic        ok_q, ok_f;
	logic [2:0]  part_q, part_f;
	logic [2:0]  dig_q, dig_f;
	logic [9:0]  val_q, val_f;
	logic        fz_q, fz_f;
	logic [31:0] addr_q, addr_f;

	always_comb begin
		ok_f   = ok_q;
		part_f = part_q;
		dig_f  = dig_q;
		val_f  = val_q;
		fz_f   = fz_q;
		addr_f = addr_q;
		if (ctl.kill) begin
			ok_f = 1'b0;
		end else if (ctl.feed) begin
			if (ch inside {[CH_0:CH_9]}) begin
				if (dig_q == '0) begin
					fz_f  = (ch[3:0] == 4'd0);
					val_f = {6'd0, ch[3:0]};
					dig_f = 3'd1;
				end else begin
					if (fz_q) ok_f = 1'b0;
					if (dig_q >= V4_MAX_DIGITS) begin
						ok_f  = 1'b0;
						dig_f = V4_MAX_DIGITS + 3'd1;
					end else begin
						val_f = (val_q << 3) + (val_q << 1) + {6'd0, ch[3:0]};
						dig_f = dig_q + 3'd1;
					end
				end
			end else if (ch == CH_DOT) begin
				if (dig_q == '0 || val_q > V4_MAX_VALUE || part_q >= V4_PARTS) begin
					ok_f = 1'b0;
				end else begin
					addr_f = {addr_q[23:0], val_q[7:0]};
					part_f = part_q + 3'd1;
				end
				dig_f = '0;
				val_f = '0;
				fz_f  = 1'b0;
			end else begin
				ok_f = 1'b0;
			end
		end
	end

	// closing the last part: it must be the fourth one
	assign fin_ok   = ok_f && (dig_f != '0) && (val_f <= V4_MAX_VALUE)
	                  && (part_f == V4_LAST_PART);
	assign fin_addr = {addr_f[23:0], val_f[7:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q   <= 1'b1;
			part_q <= '0;
			dig_q  <= '0;
			val_q  <= '0;
			fz_q   <= 1'b0;
			addr_q <= '0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				ok_q   <= 1'b1;
				part_q <= '0;
				dig_q  <= '0;
				val_q  <= '0;
				fz_q   <= 1'b0;
				addr_q <= '0;
			end else begin
				ok_q   <= ok_f;
				part_q <= part_f;
				dig_q  <= dig_f;
				val_q  <= val_f;
				fz_q   <= fz_f;
				addr_q <= addr_f;
			end
		end
	end

endmodule

// ===== src/ipat_v6.sv =====
// Hex-group tracker: group storage, double-colon handling and gap expansion.
module ipat_v6 import ipat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  step_t       ctl,
	input  logic [7:0]  ch,
	output logic        fin_ok,
	output logic [63:0] fin_high,
	output logic [63:0] fin_low
);

	logic        ok_q, ok_f;
	logic [3:0]  cnt_q, cnt_f, cnt_n;
	logic [2:0]  dig_q, dig_f;
	logic        gap_q, gap_f;
	logic        colon_q, colon_f;
	logic [3:0]  left_q, left_f;
	logic [15:0] cur_q, cur_f;
	logic        push, fin_push;
	logic [3:0]  h;
	logic [2:0]  right;
	// groups before the gap sit at their own index; groups after it shift in from the top
	logic [15:0] row_q [8];
	logic [15:0] row_f [8];
	logic [15:0] row_n [8];
	logic [15:0] rsh_q [8];
	logic [15:0] rsh_f [8];
	logic [15:0] rsh_n [8];
	logic [15:0] grp   [8];

	assign h = hex_val(ch);

	always_comb begin
		ok_f    = ok_q;
		cnt_f   = cnt_q;
		dig_f   = dig_q;
		gap_f   = gap_q;
		colon_f = colon_q;
		left_f  = left_q;
		cur_f   = cur_q;
		push    = 1'b0;
		if (ctl.kill) begin
			ok_f = 1'b0;
		end else if (ctl.feed) begin
			if (is_hex(ch)) begin
				if (colon_q && !gap_q && cnt_q == '0) ok_f = 1'b0;
				colon_f = 1'b0;
				if (cnt_q >= V6_GROUPS) begin
					ok_f = 1'b0;
				end else if (dig_q == '0) begin
					cur_f = {12'd0, h};
					dig_f = 3'd1;
				end else if (dig_q >= V6_MAX_DIGITS) begin
					ok_f  = 1'b0;
					dig_f = V6_MAX_DIGITS + 3'd1;
				end else begin
					cur_f = {cur_q[11:0], h};
					dig_f = dig_q + 3'd1;
				end
			end else if (ch == CH_COLON) begin
				if (colon_q) begin
					if (gap_q) begin
						ok_f = 1'b0;
					end else begin
						gap_f   = 1'b1;
						colon_f = 1'b0;
						left_f  = cnt_q;
					end
				end else if (dig_q != '0) begin
					push    = 1'b1;
					cnt_f   = cnt_q + 4'd1;
					dig_f   = '0;
					colon_f = 1'b1;
				end else if (cnt_q == '0 && !gap_q) begin
					colon_f = 1'b1;
				end else begin
					ok_f = 1'b0;
				end
			end else begin
				ok_f = 1'b0;
			end
		end
	end

	// group closed by a colon
	always_comb begin
		row_f = row_q;
		rsh_f = rsh_q;
		if (push) begin
			if (gap_q) begin
				for (int k = 0; k < 7; k++) rsh_f[k] = rsh_q[k + 1];
				rsh_f[7] = cur_q;
			end else begin
				row_f[cnt_q[2:0]] = cur_q;
			end
		end
	end

	// group still open at the end of the text
	assign fin_push = (dig_f != '0);
	assign cnt_n    = cnt_f + {3'd0, fin_push};

	always_comb begin
		row_n = row_f;
		rsh_n = rsh_f;
		if (fin_push) begin
			if (gap_f) begin
				for (int k = 0; k < 7; k++) rsh_n[k] = rsh_f[k + 1];
				rsh_n[7] = cur_f;
			end else begin
				row_n[cnt_f[2:0]] = cur_f;
			end
		end
	end

	assign fin_ok = ok_f && !colon_f
	                && (gap_f ? (cnt_n <= V6_GAP_GROUPS) : (cnt_n == V6_GROUPS));
	assign right  = cnt_n[2:0] - left_f[2:0];

	always_comb begin
		logic [3:0] jj;
		for (int j = 0; j < 8; j++) begin
			jj = 4'(j);
			if (!gap_f || jj < left_f) begin
				grp[j] = row_n[j];
			end else if (jj + {1'b0, right} >= V6_GROUPS) begin
				grp[j] = rsh_n[j];
			end else begin
				grp[j] = '0;
			end
		end
	end

	assign fin_high = {grp[0], grp[1], grp[2], grp[3]};
	assign fin_low  = {grp[4], grp[5], grp[6], grp[7]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q    <= 1'b1;
			cnt_q   <= '0;
			dig_q   <= '0;
			gap_q   <= 1'b0;
			colon_q <= 1'b0;
			left_q  <= '0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				ok_q    <= 1'b1;
				cnt_q   <= '0;
				dig_q   <= '0;
				gap_q   <= 1'b0;
				colon_q <= 1'b0;
				left_q  <= '0;
			end else begin
				ok_q    <= ok_f;
				cnt_q   <= cnt_f;
				dig_q   <= dig_f;
				gap_q   <= gap_f;
				colon_q <= colon_f;
				left_q  <= left_f;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && !ctl.last) begin
			cur_q <= cur_f;
			row_q <= row_f;
			rsh_q <= rsh_f;
		end
	end

endmodule

// ===== src/ip_address_text_parser.sv =====
// IP address text parser top level: input register, trim control and result register.
//
// Takes an address text one ASCII character per request on the text channel and,
// on the character flagged last, returns one request on the addr channel: kind
// (none, IPv4, IPv6) and the 128-bit address (IPv4 sits in addr_low[31:0], first
// part in the top byte; IPv6 group 0 is in addr_high[63:48]). Surrounding space,
// tab, CR and LF are skipped; a text of only whitespace yields kind none.
// Rate: one character per clock, sustained. Each character is registered, then the
// trackers update their counters and flags in a single pass, and a last character
// loads the result register in that same pass as it leaves the input register, so
// a result is on the addr channel from the edge that takes its last character out
// of the input register, and can be taken at the edge after that. The only back
// pressure is a last character waiting on a full result register that is stalled;
// characters that are not last never wait. No clearing pass after reset.
module ip_address_text_parser import ipat_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  text_valid,
	output logic  text_stall,
	input  text_t text,
	output logic  addr_valid,
	input  logic  addr_stall,
	output addr_t addr
);

	`include "ip_address_text_parser_assert.svh"

	// input register
	logic  text_valid_s1;
	text_t text_s1;
	logic  text_take;
	logic  adv;

	// result register
	logic  addr_valid_q;
	addr_t addr_q;
	addr_t res;

	// trim state
	trim_t trim_q, trim_nx;
	logic  sp;
	logic  feed, kill;
	step_t ctl;

	logic        v4_ok;
	logic [31:0] v4_addr;
	logic        v6_ok;
	logic [63:0] v6_high, v6_low;

	// a non-last character always moves on; a last one needs room in the result register
	assign adv        = text_valid_s1 && (!text_s1.last || !addr_valid_q || !addr_stall);
	assign text_stall = text_valid_s1 && !adv;
	assign text_take  = text_valid && !text_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid_s1 <= 1'b0;
		end else if (text_take) begin
			text_valid_s1 <= 1'b1;
		end else if (adv) begin
			text_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_take) begin
			text_s1 <= text;
		end
	end

	assign sp = is_space(text_s1.in_char);

	// trim next state
	always_comb begin
		trim_nx = trim_q;
		case (trim_q)
			TRIM_LEAD: if (!sp) trim_nx = TRIM_BODY;
			TRIM_BODY: if (sp) trim_nx = TRIM_TAIL;
			TRIM_TAIL: trim_nx = TRIM_TAIL;
			default:   trim_nx = TRIM_LEAD;
		endcase
	end

	// trim outputs: content goes to the trackers, content after trailing space kills both
	always_comb begin
		feed = 1'b0;
		kill = 1'b0;
		case (trim_q)
			TRIM_LEAD, TRIM_BODY: feed = !sp;
			TRIM_TAIL:            kill = !sp;
			default: begin
				feed = 1'b0;
				kill = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q <= TRIM_LEAD;
		end else if (adv) begin
			trim_q <= text_s1.last ? TRIM_LEAD : trim_nx;
		end
	end

	assign ctl = '{step: adv, feed: feed, kill: kill, last: text_s1.last};

	ipat_v4 u_v4 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.ch       (text_s1.in_char),
		.fin_ok   (v4_ok),
		.fin_addr (v4_addr)
	);

	ipat_v6 u_v6 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.ch       (text_s1.in_char),
		.fin_ok   (v6_ok),
		.fin_high (v6_high),
		.fin_low  (v6_low)
	);

	// IPv4 wins over IPv6; whitespace-only text never left the leading phase
	always_comb begin
		res = '{kind: KIND_NONE, addr_high: '0, addr_low: '0};
		if (trim_nx != TRIM_LEAD) begin
			if (v4_ok) begin
				res.kind     = KIND_V4;
				res.addr_low = {32'd0, v4_addr};
			end else if (v6_ok) begin
				res.kind      = KIND_V6;
				res.addr_high = v6_high;
				res.addr_low  = v6_low;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_valid_q <= 1'b0;
		end else if (adv && text_s1.last) begin
			addr_valid_q <= 1'b1;
		end else if (!addr_stall) begin
			addr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && text_s1.last) begin
			addr_q <= res;
		end
	end

	assign addr_valid = addr_valid_q;
	assign addr       = addr_q;

	`IPAT_ASSERT_NOW(a_v4_shape, addr_valid && addr.kind == KIND_V4, addr.addr_high == '0 && addr.addr_low[63:32] == '0, "IPv4 result carries bits above the low word")
	`IPAT_ASSERT_NOW(a_none_zero, addr_valid && addr.kind == KIND_NONE, addr.addr_high == '0 && addr.addr_low == '0, "invalid result carries a nonzero address")
	`IPAT_ASSERT_NOW(a_inner_flow, text_valid_s1 && !text_s1.last, !text_stall, "non-last character held back")
	`IPAT_ASSERT_NEXT(a_result_load, adv && text_s1.last, addr_valid, "last character produced no result")

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for ip_address_text_parser: directed and random address texts, scored per result.
module tb;
	import ipat_pkg::*;

	localparam int ITEM_TARGET  = 1600;    // minimum number of characters to send
	localparam int CYCLE_LIMIT  = 400000;  // well beyond the slowest legal run
	localparam int HOLD_CYCLES  = 400;     // one long receiver hold-off
	localparam int DRAIN_CYCLES = 10;      // settling time after the last expected result is checked

	typedef logic [7:0] byte_q_t[$];

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	// Tracks both address forms character by character and keeps the
	// answers still owed by the block, oldest first.
	class addr_scoreboard;
		trim_t       trim;
		logic        v4_ok, v4_lead_zero;
		logic [2:0]  v4_parts, v4_digits;
		logic [9:0]  v4_value;
		logic [31:0] v4_addr;
		logic        v6_ok, v6_gap, v6_colon;
		logic [3:0]  v6_groups, v6_left;
		logic [2:0]  v6_digits;
		logic [15:0] v6_store[8];
		addr_t       expected_addrs[$];
		int          fail_count;

		function new();
			fail_count = 0;
			clear();
		endfunction

		function void clear();
			trim         = TRIM_LEAD;
			v4_ok        = 1'b1;
			v4_lead_zero = 1'b0;
			v4_parts     = '0;
			v4_digits    = '0;
			v4_value     = '0;
			v4_addr      = '0;
			v6_ok        = 1'b1;
			v6_gap       = 1'b0;
			v6_colon     = 1'b0;
			v6_groups    = '0;
			v6_left      = '0;
			v6_digits    = '0;
			foreach (v6_store[i]) v6_store[i] = '0;
		endfunction

		// closes a decimal part on a dot or at the end of the text
		function void end_part();
			if (v4_digits == 0 || v4_value > V4_MAX_VALUE || v4_parts >= V4_PARTS) begin
				v4_ok = 1'b0;
			end else begin
				v4_addr  = {v4_addr[23:0], v4_value[7:0]};
				v4_parts = v4_parts + 3'd1;
			end
			v4_digits    = '0;
			v4_value     = '0;
			v4_lead_zero = 1'b0;
		endfunction

		function int hex_digit(logic [7:0] c);
			if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
			if (c >= CH_LA && c <= CH_LF_HI) return int'(c - CH_LA) + 10;
			if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
			return -1;
		endfunction

		function void note_char(text_t t);
			logic [7:0]  c;
			int          h, left, total, right;
			logic [2:0]  slot;
			logic [15:0] g[8];
			addr_t       want;
			c    = t.in_char;
			h    = hex_digit(c);
			slot = v6_groups[2:0];
			if (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF) begin
				if (trim == TRIM_BODY) trim = TRIM_TAIL;
			end else if (trim != TRIM_TAIL) begin
				trim = TRIM_BODY;
				// decimal form
				if (c >= CH_0 && c <= CH_9) begin
					if (v4_digits == 0) begin
						v4_lead_zero = (c == CH_0);
						v4_value     = 10'(c - CH_0);
						v4_digits    = 3'd1;
					end else begin
						if (v4_lead_zero) v4_ok = 1'b0;
						if (v4_digits >= V4_MAX_DIGITS) begin
							v4_ok     = 1'b0;
							v4_digits = V4_MAX_DIGITS + 3'd1;
						end else begin
							v4_value  = v4_value * 10'd10 + 10'(c - CH_0);
							v4_digits = v4_digits + 3'd1;
						end
					end
				end else if (c == CH_DOT) begin
					end_part();
				end else begin
					v4_ok = 1'b0;
				end
				// hex form
				if (h >= 0) begin
					if (v6_colon && !v6_gap && v6_groups == 0) v6_ok = 1'b0;
					v6_colon = 1'b0;
					if (v6_groups >= V6_GROUPS) begin
						v6_ok = 1'b0;
					end else if (v6_digits == 0) begin
						v6_store[slot] = {12'd0, h[3:0]};
						v6_digits      = 3'd1;
					end else if (v6_digits >= V6_MAX_DIGITS) begin
						v6_ok     = 1'b0;
						v6_digits = V6_MAX_DIGITS + 3'd1;
					end else begin
						v6_store[slot] = {v6_store[slot][11:0], h[3:0]};
						v6_digits      = v6_digits + 3'd1;
					end
				end else if (c == CH_COLON) begin
					if (v6_colon) begin
						if (v6_gap) begin
							v6_ok = 1'b0;
						end else begin
							// double colon: remember how many groups sit left of it
							v6_gap   = 1'b1;
							v6_colon = 1'b0;
							v6_left  = v6_groups;
						end
					end else if (v6_digits > 0) begin
						v6_groups = v6_groups + 4'd1;
						v6_digits = '0;
						v6_colon  = 1'b1;
					end else if (v6_groups == 0 && !v6_gap) begin
						v6_colon = 1'b1;
					end else begin
						v6_ok = 1'b0;
					end
				end else begin
					v6_ok = 1'b0;
				end
			end else begin
				// text resumes after trailing whitespace
				v4_ok = 1'b0;
				v6_ok = 1'b0;
			end

			if (!t.last) return;

			want.kind      = KIND_NONE;
			want.addr_high = '0;
			want.addr_low  = '0;
			if (trim != TRIM_LEAD) begin
				end_part();
				if (v4_parts != V4_PARTS) v4_ok = 1'b0;
				if (v6_digits > 0) begin
					v6_groups = v6_groups + 4'd1;
					v6_digits = '0;
				end
				if (v6_colon) v6_ok = 1'b0;
				if (v6_gap) begin
					if (v6_groups > V6_GAP_GROUPS) v6_ok = 1'b0;
				end else if (v6_groups != V6_GROUPS) begin
					v6_ok = 1'b0;
				end
				if (v4_ok) begin
					want.kind     = KIND_V4;
					want.addr_low = {32'd0, v4_addr};
				end else if (v6_ok) begin
					foreach (g[i]) g[i] = '0;
					if (v6_gap) begin
						// zero groups fill the space between the left and right runs
						left  = v6_left;
						total = v6_groups[2:0];
						if (left > total) left = total;
						right = total - left;
						for (int i = 0; i < left; i++) g[i] = v6_store[i];
						for (int i = 0; i < right; i++) g[8 - right + i] = v6_store[left + i];
					end else begin
						foreach (g[i]) g[i] = v6_store[i];
					end
					want.kind      = KIND_V6;
					want.addr_high = {g[0], g[1], g[2], g[3]};
					want.addr_low  = {g[4], g[5], g[6], g[7]};
				end
			end
			expected_addrs = {expected_addrs, want};
			clear();
		endfunction

		function void check_result(addr_t got);
			addr_t want;
			if (expected_addrs.size() == 0) begin
				$error("unexpected result: kind %0d addr_high %h addr_low %h",
					got.kind, got.addr_high, got.addr_low);
				fail_count++;
				return;
			end
			want = expected_addrs.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				fail_count++;
			end
			if (got.addr_high !== want.addr_high) begin
				$error("addr_high: expected %h, got %h", want.addr_high, got.addr_high);
				fail_count++;
			end
			if (got.addr_low !== want.addr_low) begin
				$error("addr_low: expected %h, got %h", want.addr_low, got.addr_low);
				fail_count++;
			end
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n;
	logic  text_valid;
	logic  text_stall;
	text_t text;
	logic  addr_valid;
	logic  addr_stall;
	addr_t addr;

	addr_scoreboard sb;
	int   cycle_count = 0;
	int   sent_chars  = 0;
	int   burst_left  = 0;
	logic steady      = 1'b0;  // sender runs with no gaps while set
	logic hold_wanted = 1'b0;  // asks the receiver for one long hold-off

	// Directed texts: the forms, their limits and the malformed shapes.
	string directed_texts[$] = {
		"1.2.3.4", "0.0.0.0", " 255.255.255.255\t\015\n", "256.1.1.1", "01.1.1.1",
		"1.2.3", "1.2.3.4.5", "1234.1.1.1", "1.2 .3.4", " \t ", "1.2.3.4x",
		"::", "::1", "1::", "fe80::1:2", "FFFF:0:0:0:0:0:0:aBcD",
		"1:2:3:4:5:6:7:8:9", "1:2:3:4:5:6:7::8", ":1:2:3:4:5:6:7",
		"1:2:3:4:5:6:7:", ":::", "1::2::3", "12345::", "::1.2.3.4"
	};

	ip_address_text_parser DUT (
		.clk,
		.arst_n,
		.text_valid,
		.text_stall,
		.text,
		.addr_valid,
		.addr_stall,
		.addr
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Values sampled at the edge are the ones that edge acts on.
	always @(posedge clk) begin
		if (arst_n) begin
			if (text_valid && !text_stall) sb.note_char(text);
			if (addr_valid && !addr_stall) sb.check_result(addr);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [7:0] ws_char();
		case ($urandom_range(0, 3))
			0:       return CH_SP;
			1:       return CH_TAB;
			2:       return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] any_char();
		case ($urandom_range(0, 5))
			0:       return CH_0 + 8'($urandom_range(0, 9));
			1:       return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'($urandom_range(0, 5));
			2:       return CH_DOT;
			3:       return CH_COLON;
			4:       return ws_char();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one hex group, mixed case, now and then one digit too many
	function automatic byte_q_t hex_group();
		byte_q_t g;
		int      d;
		repeat (($urandom_range(0, 30) == 0) ? 5 : $urandom_range(1, 4)) begin
			d = $urandom_range(0, 15);
			if (d < 10) g = {g, CH_0 + 8'(d)};
			else g = {g, ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(d - 10)};
		end
		return g;
	endfunction

	// Mostly well-formed addresses with random content; the rest broken or noise.
	task automatic build_text(output byte_q_t q);
		int    pick, left, right, value, k, i;
		string digits;
		q = {};
		pick = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) q = {q, ws_char()};
		if (pick <= 2) begin
			for (k = 0; k < 4; k++) begin
				if (k > 0) q = {q, CH_DOT};
				if ($urandom_range(0, 19) == 0) q = {q, CH_0};
				value = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 999) : $urandom_range(0, 255);
				digits = $sformatf("%0d", value);
				for (i = 0; i < digits.len(); i++) q = {q, digits[i]};
			end
		end else if (pick <= 5) begin
			for (k = 0; k < 8; k++) begin
				if (k > 0) q = {q, CH_COLON};
				q = {q, hex_group()};
			end
		end else if (pick <= 8) begin
			left  = $urandom_range(0, 7);
			right = $urandom_range(0, 7 - left);
			for (k = 0; k < left; k++) begin
				if (k > 0) q = {q, CH_COLON};
				q = {q, hex_group()};
			end
			q = {q, CH_COLON};
			q = {q, CH_COLON};
			for (k = 0; k < right; k++) begin
				if (k > 0) q = {q, CH_COLON};
				q = {q, hex_group()};
			end
		end else begin
			repeat ($urandom_range(1, 12)) q = {q, any_char()};
		end
		// one random edit breaks a well-formed text now and then
		if (pick <= 8 && $urandom_range(0, 4) == 0) begin
			k = $urandom_range(0, q.size() - 1);
			case ($urandom_range(0, 2))
				0:       q[k] = any_char();
				1:       q.insert(k, any_char());
				default: if (q.size() > 1) q.delete(k);
			endcase
		end
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) q = {q, ws_char()};
	endtask

	// Offers one character; the sender pauses between bursts unless steady.
	task automatic put_char(input logic [7:0] c, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (steady) gap = 0;
			else if ($urandom_range(0, 7) == 0) gap = $urandom_range(5, 20);
			else gap = $urandom_range(0, 3);
			if (gap > 0) begin
				text_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		text_valid <= 1'b1;
		text       <= '{in_char: c, last: fin};
		@(posedge clk);
		while (text_stall) @(posedge clk);
		sent_chars++;
	endtask

	task automatic send_bytes(input byte_q_t q);
		foreach (q[i]) put_char(q[i], i == q.size() - 1);
	endtask

	task automatic send_text(input string s);
		byte_q_t q;
		int      i;
		for (i = 0; i < s.len(); i++) q = {q, s[i]};
		send_bytes(q);
	endtask

	// Receiver: stall pattern is redrawn each time the current mode runs out, with one long hold-off
	// on request so the result register fills and last characters back up.
	initial begin : receiver
		stall_mode_t mode;
		int          mode_left, hold_left, tick;
		mode       = STALL_NONE;
		mode_left  = 0;
		hold_left  = 0;
		tick       = 0;
		addr_stall = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_left > 0) begin
				hold_left--;
				addr_stall <= 1'b1;
			end else if (hold_wanted) begin
				hold_wanted = 1'b0;
				hold_left   = HOLD_CYCLES;
				addr_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					STALL_NONE:  addr_stall <= 1'b0;
					STALL_LIGHT: addr_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: addr_stall <= ($urandom_range(0, 3) != 0);
					default:     addr_stall <= (tick % 7 < 3);
				endcase
			end
		end
	end

	initial begin : stimulus
		byte_q_t q;
		logic    hold_asked;
		hold_asked = 1'b0;
		sb         = new();
		arst_n     = 1'b0;
		text_valid = 1'b0;
		text       = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_texts[i]) send_text(directed_texts[i]);
		// byte extremes, each as a one-character text
		send_bytes({8'h00});
		send_bytes({8'hFF});

		while (sent_chars < ITEM_TARGET) begin
			if (!hold_asked && sent_chars >= ITEM_TARGET / 2) begin
				hold_asked  = 1'b1;
				hold_wanted = 1'b1;
			end
			if ($urandom_range(0, 7) == 0) steady = !steady;
			build_text(q);
			send_bytes(q);
		end
		text_valid <= 1'b0;

		// let the final request be noted, then drain
		@(posedge clk);
		while (sb.expected_addrs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
